// ===== src/ray_rectangle_intersect_top_assert.svh =====
// ----------------------------------------------------------------------------
// Ray/rectangle intersect assertion macros
// Shared concurrent assertion forms for the intersect block.
// ----------------------------------------------------------------------------
`ifndef RAY_RECTANGLE_INTERSECT_TOP_ASSERT_SVH
`define RAY_RECTANGLE_INTERSECT_TOP_ASSERT_SVH

// Same-cycle implication.
`define RRI_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rri assertion failed");

// Next-cycle implication.
`define RRI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rri assertion failed");

`endif

// ===== src/rri_pkg.sv =====
// ----------------------------------------------------------------------------
// rri_pkg
// Types, constants and helpers for the ray/rectangle intersect block.
// ----------------------------------------------------------------------------
package rri_pkg;

    localparam int ADDR_W    = 6;
    localparam int DATA_W    = 64;
    localparam int DIV_STEPS = 31;
    localparam int EPS_Q28   = 2684;
    localparam logic [30:0] T_MAX = 31'h7FFF_FFFF;

    typedef enum logic [2:0] {
        REG_CORNER_X     = 3'd0,
        REG_CORNER_Y     = 3'd1,
        REG_CORNER_Z     = 3'd2,
        REG_NORMAL       = 3'd3,
        REG_TANGENT      = 3'd4,
        REG_BITANGENT    = 3'd5,
        REG_EXT_TANGENT  = 3'd6,
        REG_EXT_BITANGENT = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [31:0] origin_x;
        logic [31:0] origin_y;
        logic [31:0] origin_z;
        logic [15:0] dir_x;
        logic [15:0] dir_y;
        logic [15:0] dir_z;
    } t_ray_in;

    typedef struct packed {
        logic        hit;
        logic [30:0] distance;
    } t_hit_out;

    typedef struct packed {
        logic [31:0] corner_x;
        logic [31:0] corner_y;
        logic [31:0] corner_z;
        logic [47:0] normal;
        logic [47:0] tangent;
        logic [47:0] bitangent;
        logic [30:0] ext_t;
        logic [30:0] ext_b;
    } t_cfg;

    // Ray geometry carried down the pipeline.
    typedef struct packed {
        logic [32:0] diff_x;
        logic [32:0] diff_y;
        logic [32:0] diff_z;
        logic [15:0] dir_x;
        logic [15:0] dir_y;
        logic [15:0] dir_z;
        logic        miss;
    } t_geo;

    function automatic logic signed [15:0] vec_comp(input logic [47:0] v,
                                                    input logic [1:0] idx);
        return $signed(v[16*idx +: 16]);
    endfunction

endpackage

// ===== src/rri_cfg.sv =====
// ----------------------------------------------------------------------------
// rri_cfg
// APB register file holding the rectangle description.
// ----------------------------------------------------------------------------
module rri_cfg import rri_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx idx;

    assign idx    = t_reg_idx'(paddr[ADDR_W-1:3]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (idx)
                REG_CORNER_X:      r_cfg.corner_x  <= pwdata[31:0];
                REG_CORNER_Y:      r_cfg.corner_y  <= pwdata[31:0];
                REG_CORNER_Z:      r_cfg.corner_z  <= pwdata[31:0];
                REG_NORMAL:        r_cfg.normal    <= pwdata[47:0];
                REG_TANGENT:       r_cfg.tangent   <= pwdata[47:0];
                REG_BITANGENT:     r_cfg.bitangent <= pwdata[47:0];
                REG_EXT_TANGENT:   r_cfg.ext_t     <= pwdata[30:0];
                REG_EXT_BITANGENT: r_cfg.ext_b     <= pwdata[30:0];
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_CORNER_X:      prdata = {32'd0, r_cfg.corner_x};
            REG_CORNER_Y:      prdata = {32'd0, r_cfg.corner_y};
            REG_CORNER_Z:      prdata = {32'd0, r_cfg.corner_z};
            REG_NORMAL:        prdata = {16'd0, r_cfg.normal};
            REG_TANGENT:       prdata = {16'd0, r_cfg.tangent};
            REG_BITANGENT:     prdata = {16'd0, r_cfg.bitangent};
            REG_EXT_TANGENT:   prdata = {33'd0, r_cfg.ext_t};
            REG_EXT_BITANGENT: prdata = {33'd0, r_cfg.ext_b};
        endcase
    end

endmodule

// ===== src/rri_front.sv =====
// ----------------------------------------------------------------------------
// rri_front
// Plane test: dot products, parallel and behind checks, divider operands.
// ----------------------------------------------------------------------------
module rri_front import rri_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_ray_in     i_ray,
    input  t_cfg        i_cfg,
    output logic        o_valid,
    output t_geo        o_geo,
    output logic [31:0] o_ad,
    output logic [31:0] o_rem,
    output logic [16:0] o_low,
    output logic        o_sat
);

    logic               r_v1, r_v2, r_v3, r_v4;
    logic signed [32:0] r_diff1 [3];
    logic signed [32:0] r_diff2 [3];
    logic signed [32:0] r_diff3 [3];
    logic signed [15:0] r_dir1  [3];
    logic signed [15:0] r_dir2  [3];
    logic signed [15:0] r_dir3  [3];
    logic signed [31:0] r_dn    [3];
    logic signed [48:0] r_dnum  [3];
    logic signed [33:0] r_don2, r_don3;
    logic signed [50:0] r_num;

    logic signed [31:0] org    [3];
    logic signed [31:0] crn    [3];
    logic signed [15:0] dir_in [3];
    logic signed [50:0] n_abs_num;
    logic signed [33:0] n_abs_don;
    logic               n_miss;
    t_geo               r_geo;
    logic [31:0]        r_ad, r_rem;
    logic [16:0]        r_low;
    logic               r_sat;

    assign org[0] = $signed(i_ray.origin_x);
    assign org[1] = $signed(i_ray.origin_y);
    assign org[2] = $signed(i_ray.origin_z);
    assign crn[0] = $signed(i_cfg.corner_x);
    assign crn[1] = $signed(i_cfg.corner_y);
    assign crn[2] = $signed(i_cfg.corner_z);
    assign dir_in[0] = $signed(i_ray.dir_x);
    assign dir_in[1] = $signed(i_ray.dir_y);
    assign dir_in[2] = $signed(i_ray.dir_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_diff1[i] <= 33'(org[i]) - 33'(crn[i]);
                r_dir1[i]  <= dir_in[i];
                r_dn[i]    <= dir_in[i] * vec_comp(i_cfg.normal, 2'(i));
                r_dnum[i]  <= 49'(r_diff1[i]) * 49'(vec_comp(i_cfg.normal, 2'(i)));
                r_diff2[i] <= r_diff1[i];
                r_dir2[i]  <= r_dir1[i];
                r_diff3[i] <= r_diff2[i];
                r_dir3[i]  <= r_dir2[i];
            end
            r_don2 <= 34'(r_dn[0]) + 34'(r_dn[1]) + 34'(r_dn[2]);
            r_don3 <= r_don2;
            r_num  <= -(51'(r_dnum[0]) + 51'(r_dnum[1]) + 51'(r_dnum[2]));
        end
    end

    always_comb begin
        n_abs_num = (r_num < 0) ? -r_num : r_num;
        n_abs_don = (r_don3 < 0) ? -r_don3 : r_don3;
        n_miss = ((r_don3 >= -34'(EPS_Q28)) && (r_don3 <= 34'(EPS_Q28)))
              || ((r_num != '0) && ((r_num < 0) != (r_don3 < 0)));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_geo.diff_x <= r_diff3[0];
            r_geo.diff_y <= r_diff3[1];
            r_geo.diff_z <= r_diff3[2];
            r_geo.dir_x  <= r_dir3[0];
            r_geo.dir_y  <= r_dir3[1];
            r_geo.dir_z  <= r_dir3[2];
            r_geo.miss   <= n_miss;
            r_ad  <= n_abs_don[31:0];
            r_rem <= n_abs_num[48:17];
            r_low <= n_abs_num[16:0];
            r_sat <= (n_abs_num[49:17] >= {1'b0, n_abs_don[31:0]});
        end
    end

    assign o_valid = r_v4;
    assign o_geo   = r_geo;
    assign o_ad    = r_ad;
    assign o_rem   = r_rem;
    assign o_low   = r_low;
    assign o_sat   = r_sat;

endmodule

// ===== src/rri_div.sv =====
// ----------------------------------------------------------------------------
// rri_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rri_div import rri_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  t_geo                 i_geo,
    input  logic [31:0]          i_ad,
    input  logic [31:0]          i_rem,
    input  logic [16:0]          i_low,
    input  logic                 i_sat,
    output logic                 o_valid,
    output t_geo                 o_geo,
    output logic [DIV_STEPS-1:0] o_q,
    output logic                 o_sat
);

    logic                 r_v    [1:DIV_STEPS];
    t_geo                 r_geo  [1:DIV_STEPS];
    logic [31:0]          r_ad   [1:DIV_STEPS];
    logic [31:0]          r_rem  [1:DIV_STEPS];
    logic [DIV_STEPS-1:0] r_bits [1:DIV_STEPS];
    logic [DIV_STEPS-1:0] r_q    [1:DIV_STEPS];
    logic                 r_sat  [1:DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_stage
        logic                 v_in;
        t_geo                 geo_in;
        logic [31:0]          ad_in;
        logic [31:0]          rem_in;
        logic [DIV_STEPS-1:0] bits_in;
        logic [DIV_STEPS-1:0] q_in;
        logic                 sat_in;
        logic [32:0]          trial;
        logic                 ge;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign geo_in  = i_geo;
            assign ad_in   = i_ad;
            assign rem_in  = i_rem;
            assign bits_in = {i_low, 14'd0};
            assign q_in    = '0;
            assign sat_in  = i_sat;
        end else begin : g_rest
            assign v_in    = r_v[k];
            assign geo_in  = r_geo[k];
            assign ad_in   = r_ad[k];
            assign rem_in  = r_rem[k];
            assign bits_in = r_bits[k];
            assign q_in    = r_q[k];
            assign sat_in  = r_sat[k];
        end

        assign trial = {rem_in, bits_in[DIV_STEPS-1]};
        assign ge    = (trial >= {1'b0, ad_in});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_geo[k+1]  <= geo_in;
                r_ad[k+1]   <= ad_in;
                r_rem[k+1]  <= ge ? 32'(trial - {1'b0, ad_in}) : trial[31:0];
                r_bits[k+1] <= {bits_in[DIV_STEPS-2:0], 1'b0};
                r_q[k+1]    <= {q_in[DIV_STEPS-2:0], ge};
                r_sat[k+1]  <= sat_in;
            end
        end
    end

    assign o_valid = r_v[DIV_STEPS];
    assign o_geo   = r_geo[DIV_STEPS];
    assign o_q     = r_q[DIV_STEPS];
    assign o_sat   = r_sat[DIV_STEPS];

endmodule

// ===== src/rri_back.sv =====
// ----------------------------------------------------------------------------
// rri_back
// Hit point, edge projections, bounds check and result register.
// ----------------------------------------------------------------------------
module rri_back import rri_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  t_geo                 i_geo,
    input  logic [DIV_STEPS-1:0] i_q,
    input  logic                 i_sat,
    input  t_cfg                 i_cfg,
    output logic                 o_valid,
    output t_hit_out             o_res
);

    logic               r_v1, r_v2, r_v3, r_v4, r_v5;
    logic               r_miss1, r_miss2, r_miss3, r_miss4;
    logic [30:0]        r_q1, r_q2, r_q3, r_q4;
    logic signed [32:0] r_diff1 [3];
    logic signed [47:0] r_p     [3];
    logic signed [33:0] r_rel   [3];
    logic signed [49:0] r_pt    [3];
    logic signed [49:0] r_pb    [3];
    logic signed [51:0] r_dt, r_db;
    t_hit_out           r_res;

    logic [30:0]        n_q;
    logic signed [15:0] dir    [3];
    logic signed [32:0] diff   [3];
    logic signed [51:0] lim_t, lim_b;
    logic               n_hit;

    assign n_q = i_sat ? T_MAX : i_q;
    assign dir[0]  = $signed(i_geo.dir_x);
    assign dir[1]  = $signed(i_geo.dir_y);
    assign dir[2]  = $signed(i_geo.dir_z);
    assign diff[0] = $signed(i_geo.diff_x);
    assign diff[1] = $signed(i_geo.diff_y);
    assign diff[2] = $signed(i_geo.diff_z);
    assign lim_t = $signed({7'd0, i_cfg.ext_t, 14'd0});
    assign lim_b = $signed({7'd0, i_cfg.ext_b, 14'd0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_diff1[i] <= diff[i];
                r_p[i]     <= 48'(dir[i]) * $signed({17'd0, n_q});
                r_rel[i]   <= 34'(r_diff1[i]) + 34'(r_p[i] >>> 14);
                r_pt[i]    <= 50'(r_rel[i]) * 50'(vec_comp(i_cfg.tangent, 2'(i)));
                r_pb[i]    <= 50'(r_rel[i]) * 50'(vec_comp(i_cfg.bitangent, 2'(i)));
            end
            r_q1 <= n_q;
            r_q2 <= r_q1;
            r_q3 <= r_q2;
            r_q4 <= r_q3;
            r_miss1 <= i_geo.miss;
            r_miss2 <= r_miss1;
            r_miss3 <= r_miss2;
            r_miss4 <= r_miss3;
            r_dt <= 52'(r_pt[0]) + 52'(r_pt[1]) + 52'(r_pt[2]);
            r_db <= 52'(r_pb[0]) + 52'(r_pb[1]) + 52'(r_pb[2]);
        end
    end

    assign n_hit = !r_miss4 && (r_dt >= 0) && (r_dt <= lim_t)
                && (r_db >= 0) && (r_db <= lim_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res.hit      <= n_hit;
            r_res.distance <= n_hit ? r_q4 : '0;
        end
    end

    assign o_valid = r_v5;
    assign o_res   = r_res;

endmodule

// ===== src/ray_rectangle_intersect_top.sv =====
// ----------------------------------------------------------------------------
// ray_rectangle_intersect_top
// Fixed-point ray versus rectangle hit test with APB-programmed geometry.
// ----------------------------------------------------------------------------
// Takes one ray per clock unless stalled and returns one result per ray, in
// order, through four plane-test stages, a 31-stage restoring divider that
// forms one bit of t per stage, and five projection and output stages. The
// whole pipeline freezes while a result waits under stall. Program the
// rectangle only while no rays are in flight.
`include "ray_rectangle_intersect_top_assert.svh"

module ray_rectangle_intersect_top import rri_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              i_valid,
    output logic              o_stall,
    input  t_ray_in           i_ray,
    output logic              o_valid,
    input  logic              i_stall,
    output t_hit_out          o_res
);

    t_cfg                 cfg;
    logic                 en;
    logic                 fr_valid, dv_valid;
    t_geo                 fr_geo, dv_geo;
    logic [31:0]          fr_ad, fr_rem;
    logic [16:0]          fr_low;
    logic                 fr_sat, dv_sat;
    logic [DIV_STEPS-1:0] dv_q;

    // Hold every stage while the result beat is stalled.
    assign en      = !(o_valid && i_stall);
    assign o_stall = o_valid && i_stall;

    rri_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rri_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_ray   (i_ray),
        .i_cfg   (cfg),
        .o_valid (fr_valid),
        .o_geo   (fr_geo),
        .o_ad    (fr_ad),
        .o_rem   (fr_rem),
        .o_low   (fr_low),
        .o_sat   (fr_sat)
    );

    rri_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (fr_valid),
        .i_geo   (fr_geo),
        .i_ad    (fr_ad),
        .i_rem   (fr_rem),
        .i_low   (fr_low),
        .i_sat   (fr_sat),
        .o_valid (dv_valid),
        .o_geo   (dv_geo),
        .o_q     (dv_q),
        .o_sat   (dv_sat)
    );

    rri_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (dv_valid),
        .i_geo   (dv_geo),
        .i_q     (dv_q),
        .i_sat   (dv_sat),
        .i_cfg   (cfg),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    `RRI_ASSERT_IMPLY(a_miss_zero, i_clk, i_rst_n, o_valid && !o_res.hit, o_res.distance == '0)
    `RRI_ASSERT_IMPLY(a_stall_has_beat, i_clk, i_rst_n, o_stall, o_valid && i_stall)
    `RRI_ASSERT_NEXT(a_reset_empty, i_clk, 1'b1, !i_rst_n, !o_valid)

endmodule

// ===== verif/ray_rectangle_intersect_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ray_rectangle_intersect_checker
// Watches the register port and both ray channels of the intersect block.
// Keeps its own copy of the rectangle registers, works out the hit result of
// every accepted ray and compares each result beat, in order, field by field.
// ----------------------------------------------------------------------------
module ray_rectangle_intersect_checker import rri_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic              i_valid,
    input  logic              o_stall,
    input  t_ray_in           i_ray,
    input  logic              o_valid,
    input  logic              i_stall,
    input  t_hit_out          o_res,
    output int                o_fail_count,
    output int                o_pending
);

    t_cfg     shadow;
    t_hit_out expected_hits[$];

    assign o_pending = expected_hits.size();

    initial o_fail_count = 0;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        o_fail_count++;
    endtask

    function automatic longint vec_part(input logic [47:0] v, input int k);
        logic signed [15:0] s;
        s = v[16*k +: 16];
        return longint'(s);
    endfunction

    function automatic t_hit_out predict_hit(input t_ray_in r);
        longint nv[3], tv[3], bv[3], dv[3], df[3], rl[3];
        longint dn, nm, dt, db, lt, lb, an, ad, hi, q;
        logic signed [31:0] o32[3], c32[3];
        logic signed [15:0] d16[3];
        t_hit_out res;
        res = '0;
        o32[0] = r.origin_x; o32[1] = r.origin_y; o32[2] = r.origin_z;
        c32[0] = shadow.corner_x; c32[1] = shadow.corner_y; c32[2] = shadow.corner_z;
        d16[0] = r.dir_x; d16[1] = r.dir_y; d16[2] = r.dir_z;
        for (int k = 0; k < 3; k++) begin
            nv[k] = vec_part(shadow.normal, k);
            tv[k] = vec_part(shadow.tangent, k);
            bv[k] = vec_part(shadow.bitangent, k);
            df[k] = longint'(o32[k]) - longint'(c32[k]);
            dv[k] = longint'(d16[k]);
        end
        dn = dv[0] * nv[0] + dv[1] * nv[1] + dv[2] * nv[2];
        if (dn >= -EPS_Q28 && dn <= EPS_Q28) return res;
        nm = -(df[0] * nv[0] + df[1] * nv[1] + df[2] * nv[2]);
        if (nm != 0 && ((nm < 0) != (dn < 0))) return res;
        an = (nm < 0) ? -nm : nm;
        ad = (dn < 0) ? -dn : dn;
        hi = an / ad;
        if (hi >= (64'sd1 <<< 17)) begin
            q = longint'(T_MAX);
        end else begin
            q = (hi <<< 14) + (((an % ad) <<< 14) / ad);
            if (q > longint'(T_MAX)) q = longint'(T_MAX);
        end
        for (int k = 0; k < 3; k++) rl[k] = df[k] + ((dv[k] * q) >>> 14);
        dt = rl[0] * tv[0] + rl[1] * tv[1] + rl[2] * tv[2];
        db = rl[0] * bv[0] + rl[1] * bv[1] + rl[2] * bv[2];
        lt = longint'(shadow.ext_t) <<< 14;
        lb = longint'(shadow.ext_b) <<< 14;
        if (dt < 0 || dt > lt || db < 0 || db > lb) return res;
        res.hit = 1'b1;
        res.distance = q[30:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_hit_out want;
        if (!i_rst_n) begin
            shadow = '0;
            expected_hits.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[5:3]))
                    REG_CORNER_X:      shadow.corner_x  = pwdata[31:0];
                    REG_CORNER_Y:      shadow.corner_y  = pwdata[31:0];
                    REG_CORNER_Z:      shadow.corner_z  = pwdata[31:0];
                    REG_NORMAL:        shadow.normal    = pwdata[47:0];
                    REG_TANGENT:       shadow.tangent   = pwdata[47:0];
                    REG_BITANGENT:     shadow.bitangent = pwdata[47:0];
                    REG_EXT_TANGENT:   shadow.ext_t     = pwdata[30:0];
                    REG_EXT_BITANGENT: shadow.ext_b     = pwdata[30:0];
                    default: ;
                endcase
            end
            if (o_valid && !i_stall) begin
                if (expected_hits.size() == 0) begin
                    report_mismatch($sformatf("result beat with none expected: hit %0b dist %h",
                                              o_res.hit, o_res.distance));
                end else begin
                    want = expected_hits.pop_front();
                    if (o_res.hit !== want.hit)
                        report_mismatch($sformatf("hit got %b want %b", o_res.hit, want.hit));
                    if (o_res.distance !== want.distance)
                        report_mismatch($sformatf("distance got %h want %h",
                                                  o_res.distance, want.distance));
                end
            end
            if (i_valid && !o_stall) expected_hits.push_back(predict_hit(i_ray));
        end
    end

endmodule

// ===== verif/ray_rectangle_intersect_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ray_rectangle_intersect_top_tb
// Stimulus for the ray/rectangle intersect block: programs a series of
// rectangles over the register port, drives directed, aimed random and noise
// rays with random sender gaps and receiver stalls, and gives the verdict from
// the checker's mismatch count.
// ----------------------------------------------------------------------------
module ray_rectangle_intersect_top_tb;
    import rri_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 60;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel, penable, pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              i_valid, o_stall, o_valid, i_stall;
    t_ray_in           i_ray;
    t_hit_out          o_res;
    int                fail_count, pending;

    int gap_pct, stall_pct;
    int hold_req_n, hold_seen_n, hold_left;
    int idle_cycles;

    int     sn[3], st[3], sb[3];
    longint corner[3];
    longint ext_a, ext_b;

    ray_rectangle_intersect_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_stall(o_stall), .i_ray(i_ray),
        .o_valid(o_valid), .i_stall(i_stall), .o_res(o_res)
    );

    ray_rectangle_intersect_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .i_valid(i_valid), .o_stall(o_stall), .i_ray(i_ray),
        .o_valid(o_valid), .i_stall(i_stall), .o_res(o_res),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // receiver: random stall, or a long hold when one is requested
    initial begin
        i_stall = 1'b0;
        hold_seen_n = 0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_seen_n != hold_req_n) begin
                hold_seen_n = hold_req_n;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_stall = 1'b1;
                hold_left--;
            end else begin
                i_stall = ($urandom_range(99) < stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic reg_write(input t_reg_idx idx, input logic [63:0] val);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = ADDR_W'({idx, 3'b000});
        pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    task automatic send_ray(input t_ray_in r);
        while ($urandom_range(99) < gap_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_ray = r;
        i_valid = 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [47:0] pack_axis(input int s[3]);
        logic [47:0] v;
        for (int k = 0; k < 3; k++) v[16*k +: 16] = 16'(s[k] * 16384);
        return v;
    endfunction

    task automatic program_frame(input longint ea, input longint eb);
        reg_write(REG_CORNER_X, 64'(corner[0]));
        reg_write(REG_CORNER_Y, 64'(corner[1]));
        reg_write(REG_CORNER_Z, 64'(corner[2]));
        reg_write(REG_NORMAL, 64'(pack_axis(sn)));
        reg_write(REG_TANGENT, 64'(pack_axis(st)));
        reg_write(REG_BITANGENT, 64'(pack_axis(sb)));
        reg_write(REG_EXT_TANGENT, 64'(ea));
        reg_write(REG_EXT_BITANGENT, 64'(eb));
        ext_a = ea;
        ext_b = eb;
    endtask

    task automatic pick_frame();
        int a0, a1, a2;
        a0 = $urandom_range(2);
        a1 = (a0 + 1 + $urandom_range(1)) % 3;
        a2 = 3 - a0 - a1;
        for (int k = 0; k < 3; k++) begin
            sn[k] = 0; st[k] = 0; sb[k] = 0;
        end
        sn[a0] = $urandom_range(1) ? 1 : -1;
        st[a1] = $urandom_range(1) ? 1 : -1;
        sb[a2] = $urandom_range(1) ? 1 : -1;
    endtask

    function automatic t_ray_in make_ray(input longint o[3], input int d[3]);
        t_ray_in r;
        r.origin_x = 32'(o[0]); r.origin_y = 32'(o[1]); r.origin_z = 32'(o[2]);
        r.dir_x = 16'(d[0]); r.dir_y = 16'(d[1]); r.dir_z = 16'(d[2]);
        return r;
    endfunction

    // aim at a point around the rectangle from a height along the normal
    function automatic t_ray_in aimed_ray();
        longint o[3], u, v, h, span_a, span_b;
        int d[3];
        span_a = ext_a / 8 + 1;
        span_b = ext_b / 8 + 1;
        u = longint'($urandom_range(32'(ext_a + 2 * span_a))) - span_a;
        v = longint'($urandom_range(32'(ext_b + 2 * span_b))) - span_b;
        h = longint'($urandom_range(32'h0080_0000)) - 64'h0010_0000;
        for (int k = 0; k < 3; k++) begin
            o[k] = corner[k] + st[k] * u + sb[k] * v + sn[k] * h;
            d[k] = -sn[k] * (16384 - $urandom_range(300))
                   + (st[k] + sb[k]) * (int'($urandom_range(200)) - 100);
        end
        return make_ray(o, d);
    endfunction

    function automatic t_ray_in noise_ray();
        t_ray_in r;
        r.origin_x = $urandom; r.origin_y = $urandom; r.origin_z = $urandom;
        r.dir_x = 16'($urandom); r.dir_y = 16'($urandom); r.dir_z = 16'($urandom);
        return r;
    endfunction

    task automatic directed_ray(input longint ox, input longint oy, input longint oz,
                                input int dx, input int dy, input int dz);
        longint o[3];
        int d[3];
        o[0] = ox; o[1] = oy; o[2] = oz;
        d[0] = dx; d[1] = dy; d[2] = dz;
        send_ray(make_ray(o, d));
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        paddr = '0; pwdata = '0;
        i_valid = 1'b0; i_ray = '0;
        gap_pct = 0; stall_pct = 0;
        hold_req_n = 0;
        idle_cycles = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // reset geometry: every ray misses
        directed_ray(64'h7FFF_FFFF, 64'h8000_0000, 64'h7FFF_FFFF, 32767, -32768, 32767);
        directed_ray(0, 0, 64'h1_0000, 0, 0, -16384);
        wait_drained();

        // axis frame: normal +z, tangent +x, bitangent +y, side 4.0
        for (int k = 0; k < 3; k++) begin
            corner[k] = 0; sn[k] = 0; st[k] = 0; sb[k] = 0;
        end
        sn[2] = 1; st[0] = 1; sb[1] = 1;
        program_frame(64'h4_0000, 64'h4_0000);
        directed_ray(64'h2_0000, 64'h2_0000, 64'h5_0000, 0, 0, -16384);
        directed_ray(0, 0, 64'h3_0000, 0, 0, -16384);
        directed_ray(64'h4_0000, 64'h4_0000, 64'h3_0000, 0, 0, -16384);
        directed_ray(64'h4_0001, 64'h2_0000, 64'h3_0000, 0, 0, -16384);
        directed_ray(64'h2_0000, 64'h2_0000, -64'h5_0000, 0, 0, -16384);
        directed_ray(64'h1_0000, 64'h1_0000, 0, 5, -7, 100);
        directed_ray(64'h1_0000, 64'h1_0000, 64'h1_0000, 16384, 0, 0);
        directed_ray(0, 0, 64'h7FFF_FFFF, 0, 0, -1);
        directed_ray(64'h1_0000, 64'h1_0000, 64'h2_0000, 0, 0, -32768);
        directed_ray(64'h8000_0000, 64'h7FFF_FFFF, 64'h8000_0000, 32767, -32768, 32767);
        directed_ray(64'h2_0000, 64'h2_0000, -64'h1_0000, 0, 0, 32767);
        wait_drained();

        // tiny normal: near-parallel bound on both signs
        for (int k = 0; k < 3; k++) begin
            sn[k] = 0; st[k] = 0; sb[k] = 0;
        end
        st[1] = 1; sb[2] = 1;
        program_frame(64'h7FFF_FFFF, 64'h7FFF_FFFF);
        reg_write(REG_NORMAL, 64'h0000_0000_0001);
        directed_ray(-64'h1_0000, 64'h10, 64'h10, 2684, 0, 0);
        directed_ray(-64'h1_0000, 64'h10, 64'h10, 2685, 0, 0);
        directed_ray(64'h1_0000, 64'h10, 64'h10, -2684, 0, 0);
        directed_ray(64'h1_0000, 64'h10, 64'h10, -2685, 0, 0);
        directed_ray(-64'h1, 0, 0, 32767, 0, 0);
        wait_drained();

        for (int phase = 0; phase < 10; phase++) begin
            case (phase % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 71; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 71; end
                default: begin gap_pct = 21; stall_pct = 21; end
            endcase
            pick_frame();
            for (int k = 0; k < 3; k++)
                corner[k] = longint'($urandom_range(32'h0200_0000)) - 64'h0100_0000;
            if (phase == 2) begin
                corner[0] = 64'h7FFF_FFFF; corner[1] = -64'h8000_0000;
                corner[2] = 64'h7FFF_FFFF;
                program_frame(64'h7FFF_FFFF, 64'h7FFF_FFFF);
            end else if (phase == 7) begin
                program_frame(0, 0);
            end else begin
                program_frame($urandom_range(32'h0040_0000), $urandom_range(32'h0040_0000));
            end
            if (phase == 5) begin
                reg_write(REG_NORMAL, {16'h0, $urandom, 16'($urandom)});
                reg_write(REG_TANGENT, {16'h0, $urandom, 16'($urandom)});
                reg_write(REG_BITANGENT, {16'h0, $urandom, 16'($urandom)});
            end
            for (int n = 0; n < 100; n++) begin
                if (phase == 3 && n == 40) hold_req_n++;
                if (phase == 6 && n == 60) begin
                    i_valid = 1'b0;
                    while (pending != 0) @(negedge i_clk);
                end
                if ($urandom_range(9) < 7) send_ray(aimed_ray());
                else send_ray(noise_ray());
            end
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/rri_pkg.sv
src/rri_cfg.sv
src/rri_front.sv
src/rri_div.sv
src/rri_back.sv
src/ray_rectangle_intersect_top.sv
verif/ray_rectangle_intersect_checker.sv
verif/ray_rectangle_intersect_top_tb.sv
